@@ rtl/core/mtt_pkg.sv @@
package mtt_pkg;

  localparam int unsigned TimersDefault = 16;

  localparam int unsigned IdW     = 32;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned PeriodW = 32;

  // input item kinds
  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindStop  = 2'd1;
  localparam logic [1:0] KindTick  = 2'd2;

  // result kinds
  localparam logic [1:0] ResStart = 2'd0;
  localparam logic [1:0] ResStop  = 2'd1;
  localparam logic [1:0] ResFire  = 2'd2;
  localparam logic [1:0] ResDone  = 2'd3;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic               alive;
    logic [IdW-1:0]     id;
    logic [TimeW-1:0]   stamp;
    logic [PeriodW-1:0] period;
    logic               periodic;
  } mtt_entry_t;

  // outcome of checking one entry during a tick
  typedef struct packed {
    logic             fire;
    logic [TimeW-1:0] elapsed;
    mtt_entry_t       entry;
  } mtt_eval_t;

endpackage

@@ rtl/core/mtt_table.sv @@
module mtt_table #(
  parameter int unsigned Depth = mtt_pkg::TimersDefault,
  parameter int unsigned AddrW = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  mtt_pkg::mtt_entry_t wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output mtt_pkg::mtt_entry_t rdata_o
);
  import mtt_pkg::*;

  mtt_entry_t mem_q [Depth];
  mtt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mtt_eval.sv @@
module mtt_eval (
  input  mtt_pkg::mtt_entry_t           entry_i,
  input  logic [mtt_pkg::TimeW-1:0]     now_ms_i,
  input  logic [mtt_pkg::IdW-1:0]       last_id_i,
  input  logic                          upper_i,
  output mtt_pkg::mtt_eval_t            eval_o
);
  import mtt_pkg::*;

  logic [TimeW:0] diff;
  logic           in_pass;
  logic           due;

  // borrow out means now is before the stamp
  assign diff = {1'b0, now_ms_i} - {1'b0, entry_i.stamp};

  // lower pass takes ids up to the last issued one, upper pass the older ones above it
  assign in_pass = upper_i ? (entry_i.id > last_id_i) : (entry_i.id <= last_id_i);

  assign due = entry_i.alive && in_pass && !diff[TimeW] &&
               (diff[TimeW-1:0] >= {{(TimeW-PeriodW){1'b0}}, entry_i.period});

  always_comb begin
    eval_o.fire    = due;
    eval_o.elapsed = diff[TimeW-1:0];
    eval_o.entry   = entry_i;
    if (due) begin
      eval_o.entry.stamp = now_ms_i;
      eval_o.entry.alive = entry_i.periodic;
    end
  end

endmodule

@@ rtl/core/multi_timer_table_core.sv @@
// channel   | direction | handshake              | beat contents
// ----------+-----------+------------------------+-------------------------------------------
// command   | in        | start high, busy low   | kind, now_ms, interval_ms, repeat_flag,
//           |           |                        | target_id
// result    | out       | result_strobe_o pulse  | result_kind, timer_id, elapsed_ms,
//           |           |                        | status, last
//
// the one read port of the entry memory walks the held entries once per start or stop scan
// and twice per tick, before the reply or the tick done beat.
// a start on a full table replies in the cycle after it is taken.
// reset clears the entry count and the last issued id; the entry memory needs no clearing.
// results come out as one-cycle strobes and cannot be stalled by the receiver.

module multi_timer_table_core #(
  parameter int unsigned TIMERS = mtt_pkg::TimersDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic [mtt_pkg::TimeW-1:0]     now_ms_i,
  input  logic [mtt_pkg::PeriodW-1:0]   interval_ms_i,
  input  logic                          repeat_flag_i,
  input  logic [mtt_pkg::IdW-1:0]       target_id_i,

  output logic                          result_strobe_o,
  output logic [1:0]                    result_kind_o,
  output logic [mtt_pkg::IdW-1:0]       timer_id_o,
  output logic [mtt_pkg::TimeW-1:0]     elapsed_ms_o,
  output logic                          status_o,
  output logic                          last_o
);
  import mtt_pkg::*;

  localparam int unsigned AddrW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned CntW  = $clog2(TIMERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STOP,
    ST_TICK_LO,
    ST_TICK_HI
  } state_e;

  state_e state_q, state_d;

  // table bookkeeping: entries live compacted at positions 0 .. cnt-1 in issue order
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [IdW-1:0]     last_id_q, last_id_d;

  // scan pointers
  logic [CntW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    proc_ptr_q, proc_ptr_d;
  logic [CntW-1:0]    wr_ptr_q, wr_ptr_d;
  logic               rd_pend_q, rd_pend_d;
  logic               found_q, found_d;

  // captured command beat
  logic [TimeW-1:0]   now_q, now_d;
  logic [PeriodW-1:0] interval_q, interval_d;
  logic               repeat_q, repeat_d;
  logic [IdW-1:0]     target_q, target_d;

  // result register
  logic               res_strobe_q, res_strobe_d;
  logic [1:0]         res_kind_q, res_kind_d;
  logic [IdW-1:0]     res_id_q, res_id_d;
  logic [TimeW-1:0]   res_elapsed_q, res_elapsed_d;
  logic               res_status_q, res_status_d;
  logic               res_last_q, res_last_d;

  // memory port
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  mtt_entry_t         mem_wdata;
  logic               mem_re;
  mtt_entry_t         rd_data;

  mtt_eval_t          eval;
  mtt_entry_t         new_entry;
  mtt_entry_t         stopped_entry;
  logic [IdW-1:0]     next_id;
  logic [IdW-1:0]     inc_id;
  logic               scan_issue;
  logic               scan_end;

  mtt_table #(
    .Depth (TIMERS),
    .AddrW (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  mtt_eval u_eval (
    .entry_i   (rd_data),
    .now_ms_i  (now_q),
    .last_id_i (last_id_q),
    .upper_i   (state_q == ST_TICK_HI),
    .eval_o    (eval)
  );

  // next id skips zero on wrap
  assign inc_id  = last_id_q + {{(IdW-1){1'b0}}, 1'b1};
  assign next_id = (inc_id == '0) ? {{(IdW-1){1'b0}}, 1'b1} : inc_id;

  // one read issued per cycle, its data processed in the following cycle
  assign scan_issue = (rd_ptr_q < cnt_q);
  assign scan_end   = !scan_issue && !rd_pend_q;

  always_comb begin
    new_entry.alive    = 1'b1;
    new_entry.id       = next_id;
    new_entry.stamp    = now_q;
    new_entry.period   = interval_q;
    new_entry.periodic = repeat_q;

    stopped_entry       = rd_data;
    stopped_entry.alive = 1'b0;
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    last_id_d     = last_id_q;
    rd_ptr_d      = rd_ptr_q;
    proc_ptr_d    = proc_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    rd_pend_d     = 1'b0;
    found_d       = found_q;
    now_d         = now_q;
    interval_d    = interval_q;
    repeat_d      = repeat_q;
    target_d      = target_q;

    res_strobe_d  = 1'b0;
    res_kind_d    = res_kind_q;
    res_id_d      = res_id_q;
    res_elapsed_d = res_elapsed_q;
    res_status_d  = res_status_q;
    res_last_d    = res_last_q;

    mem_we        = 1'b0;
    mem_waddr     = proc_ptr_q[AddrW-1:0];
    mem_wdata     = rd_data;
    mem_re        = 1'b0;

    // common walk over the held entries
    if (state_q != ST_IDLE) begin
      mem_re     = scan_issue;
      rd_pend_d  = scan_issue;
      proc_ptr_d = rd_ptr_q;
      if (scan_issue) begin
        rd_ptr_d = rd_ptr_q + {{(CntW-1){1'b0}}, 1'b1};
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          now_d      = now_ms_i;
          interval_d = interval_ms_i;
          repeat_d   = repeat_flag_i;
          target_d   = target_id_i;
          rd_ptr_d   = '0;
          wr_ptr_d   = '0;
          found_d    = 1'b0;
          unique case (kind_i)
            KindStart: begin
              if (cnt_q == CntW'(TIMERS)) begin
                // table full
                res_strobe_d  = 1'b1;
                res_kind_d    = ResStart;
                res_id_d      = '0;
                res_elapsed_d = '0;
                res_status_d  = StatusBad;
                res_last_d    = 1'b1;
              end else begin
                state_d = ST_START;
              end
            end
            KindStop: state_d = ST_STOP;
            KindTick: state_d = ST_TICK_LO;
            default: ; // unused kind, no result
          endcase
        end
      end

      ST_START: begin
        // the fresh id must not clash with any entry still held
        if (rd_pend_q && (rd_data.id == next_id)) begin
          found_d = 1'b1;
        end
        if (scan_end) begin
          state_d       = ST_IDLE;
          res_strobe_d  = 1'b1;
          res_kind_d    = ResStart;
          res_elapsed_d = '0;
          res_last_d    = 1'b1;
          if (found_q) begin
            res_id_d     = '0;
            res_status_d = StatusBad;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = cnt_q[AddrW-1:0];
            mem_wdata    = new_entry;
            cnt_d        = cnt_q + {{(CntW-1){1'b0}}, 1'b1};
            last_id_d    = next_id;
            res_id_d     = next_id;
            res_status_d = StatusOk;
          end
        end
      end

      ST_STOP: begin
        // dead entry keeps its place until the next tick
        if (rd_pend_q && (rd_data.id == target_q)) begin
          mem_we    = 1'b1;
          mem_wdata = stopped_entry;
          found_d   = 1'b1;
        end
        if (scan_end) begin
          state_d       = ST_IDLE;
          res_strobe_d  = 1'b1;
          res_kind_d    = ResStop;
          res_id_d      = target_q;
          res_elapsed_d = '0;
          res_status_d  = found_q ? StatusOk : StatusBad;
          res_last_d    = 1'b1;
        end
      end

      ST_TICK_LO: begin
        // ids up to the last issued one, oldest first, which is ascending order
        if (rd_pend_q && eval.fire) begin
          mem_we        = 1'b1;
          mem_wdata     = eval.entry;
          res_strobe_d  = 1'b1;
          res_kind_d    = ResFire;
          res_id_d      = rd_data.id;
          res_elapsed_d = eval.elapsed;
          res_status_d  = StatusOk;
          res_last_d    = 1'b0;
        end
        if (scan_end) begin
          state_d  = ST_TICK_HI;
          rd_ptr_d = '0;
          wr_ptr_d = '0;
        end
      end

      ST_TICK_HI: begin
        // ids issued before the wrap, with compaction of every surviving entry in the same pass
        if (rd_pend_q) begin
          if (eval.fire) begin
            res_strobe_d  = 1'b1;
            res_kind_d    = ResFire;
            res_id_d      = rd_data.id;
            res_elapsed_d = eval.elapsed;
            res_status_d  = StatusOk;
            res_last_d    = 1'b0;
          end
          if (eval.entry.alive) begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_q[AddrW-1:0];
            mem_wdata = eval.entry;
            wr_ptr_d  = wr_ptr_q + {{(CntW-1){1'b0}}, 1'b1};
          end
        end
        if (scan_end) begin
          state_d       = ST_IDLE;
          cnt_d         = wr_ptr_q;
          res_strobe_d  = 1'b1;
          res_kind_d    = ResDone;
          res_id_d      = '0;
          res_elapsed_d = '0;
          res_status_d  = StatusOk;
          res_last_d    = 1'b1;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      last_id_q     <= '0;
      rd_ptr_q      <= '0;
      proc_ptr_q    <= '0;
      wr_ptr_q      <= '0;
      rd_pend_q     <= 1'b0;
      found_q       <= 1'b0;
      now_q         <= '0;
      interval_q    <= '0;
      repeat_q      <= 1'b0;
      target_q      <= '0;
      res_strobe_q  <= 1'b0;
      res_kind_q    <= ResStart;
      res_id_q      <= '0;
      res_elapsed_q <= '0;
      res_status_q  <= StatusOk;
      res_last_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      last_id_q     <= last_id_d;
      rd_ptr_q      <= rd_ptr_d;
      proc_ptr_q    <= proc_ptr_d;
      wr_ptr_q      <= wr_ptr_d;
      rd_pend_q     <= rd_pend_d;
      found_q       <= found_d;
      now_q         <= now_d;
      interval_q    <= interval_d;
      repeat_q      <= repeat_d;
      target_q      <= target_d;
      res_strobe_q  <= res_strobe_d;
      res_kind_q    <= res_kind_d;
      res_id_q      <= res_id_d;
      res_elapsed_q <= res_elapsed_d;
      res_status_q  <= res_status_d;
      res_last_q    <= res_last_d;
    end
  end

  assign result_strobe_o = res_strobe_q;
  assign result_kind_o   = res_kind_q;
  assign timer_id_o      = res_id_q;
  assign elapsed_ms_o    = res_elapsed_q;
  assign status_o        = res_status_q;
  assign last_o          = res_last_q;

endmodule
